FILE: hw/rtl/iidl_pkg.sv
// Package for the indexed insert/delete list.
// Holds opcodes, status codes, field widths and the cell control struct.
// No dependencies.
`default_nettype none

package iidl_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 7;
    localparam int OPCODE_W     = 3;
    localparam int STATUS_W     = 2;
    localparam int CNT_OUT_W    = 7;
    localparam int CAPACITY_DEF = 64;

    localparam logic [DATA_W-1:0] NOT_FOUND = '1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_READ   = 3'd0,
        OP_HEAD   = 3'd1,
        OP_TAIL   = 3'd2,
        OP_AT     = 3'd3,
        OP_DELETE = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Broadcast shift command for the row of cells
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: hw/rtl/iidl_cell.sv
// One storage cell of the list: holds the entry at its fixed position.
// Depends on iidl_pkg; instantiated in a row by indexed_insert_delete_list_top.
`default_nettype none

module iidl_cell
    import iidl_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CMP_W = 7
) (
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [CMP_W-1:0]  i_pos,
    input  wire logic [DATA_W-1:0] i_item_value,
    input  wire logic [DATA_W-1:0] i_left_value,
    input  wire logic [DATA_W-1:0] i_right_value,
    output logic [DATA_W-1:0]      o_value,
    output logic [DATA_W-1:0]      o_sel_value
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;
    logic              at_pos;
    logic              past_pos;

    assign at_pos   = (i_pos == MY_IDX);
    assign past_pos = (MY_IDX > i_pos);

    // Pick the new entry: shift from a neighbor, load the item, or hold
    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (past_pos) begin
                n_value = i_left_value;
            end else if (at_pos) begin
                n_value = i_item_value;
            end
        end else if (i_ctl.del) begin
            if (past_pos || at_pos) begin
                n_value = i_right_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value     = r_value;
    // Drive the entry onto the read tree only when addressed
    assign o_sel_value = at_pos ? r_value : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/indexed_insert_delete_list_top.sv
// Indexed insert/delete list: top level with decode, count and output register.
// Depends on iidl_pkg and iidl_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request beat:
//   opcode, position and item value. Output channel (o_out_valid /
//   i_out_stall) carries one result beat per request: read value, status
//   and entry count after the request.
//   The list lives in a row of CAPACITY cells, one entry each. An insert or
//   delete moves every cell past the position by one place in the same
//   edge. The result is registered and shows on the output in the cycle
//   after the request is accepted. Throughput: one request per cycle while
//   the receiver takes results. The read path is a select tree over all cells.
//   Reset (synchronous, active low) empties the list and drops any pending
//   result; the cell contents are left as they are and never show, since
//   only positions below the count are read.
//   When the receiver stalls, the result register holds its beat and the
//   input stalls until that beat is taken; no request is lost.
`default_nettype none

module indexed_insert_delete_list_top
    import iidl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [OPCODE_W-1:0]      i_opcode,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [DATA_W-1:0] i_item_value,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [DATA_W-1:0]      o_read_value,
    output logic [STATUS_W-1:0]           o_status,
    output logic [CNT_OUT_W-1:0]          o_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_read_value;
    logic [DATA_W-1:0]    n_read_value;
    t_status              r_status;
    t_status              n_status;
    logic [CNT_OUT_W-1:0] r_entry_count;

    logic                 in_acc;
    logic                 full;
    logic [CMP_W-1:0]     pos_ext;
    logic [CMP_W-1:0]     cnt_ext;
    logic [CMP_W-1:0]     n_cnt_ext;
    logic [CMP_W-1:0]     cell_pos;
    logic                 do_ins;
    logic                 do_del;
    t_cell_ctl            cell_ctl;
    t_opcode              op;
    logic [DATA_W-1:0]    sel_value;

    logic [DATA_W-1:0]    cell_value [CAPACITY];
    logic [DATA_W-1:0]    cell_sel   [CAPACITY];

    // Accept while the result register is free or being emptied
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign pos_ext = CMP_W'(i_position);
    assign cnt_ext = CMP_W'(r_count);
    assign full    = (cnt_ext >= CAP_CMP);
    assign op      = t_opcode'(i_opcode);

    // Decode the request against the current count
    always_comb begin
        do_ins   = 1'b0;
        do_del   = 1'b0;
        cell_pos = pos_ext;
        n_status = ST_DONE;
        unique case (op)
            OP_READ: begin
                if (pos_ext >= cnt_ext) begin
                    n_status = ST_RANGE;
                end
            end
            OP_HEAD: begin
                cell_pos = '0;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_TAIL: begin
                cell_pos = cnt_ext;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_AT: begin
                if (pos_ext > cnt_ext) begin
                    n_status = ST_RANGE;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_DELETE: begin
                if (pos_ext >= cnt_ext) begin
                    n_status = ST_RANGE;
                end else begin
                    do_del = 1'b1;
                end
            end
            default: begin
                n_status = ST_RANGE;
            end
        endcase
    end

    // Advance the count
    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_del) begin
            n_count = r_count - CNT_W'(1);
        end
    end
    assign n_cnt_ext = CMP_W'(n_count);

    assign cell_ctl.ins = in_acc && do_ins;
    assign cell_ctl.del = in_acc && do_del;

    // Row of cells, each linked to its neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] left_value;
        logic [DATA_W-1:0] right_value;
        if (g == 0) begin : g_first
            assign left_value = i_item_value;
        end else begin : g_inner_l
            assign left_value = cell_value[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[g];
        end else begin : g_inner_r
            assign right_value = cell_value[g+1];
        end
        iidl_cell #(
            .IDX   (g),
            .CMP_W (CMP_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl),
            .i_pos         (cell_pos),
            .i_item_value  (i_item_value),
            .i_left_value  (left_value),
            .i_right_value (right_value),
            .o_value       (cell_value[g]),
            .o_sel_value   (cell_sel[g])
        );
    end

    // Merge the addressed cell onto the read path
    always_comb begin
        sel_value = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            sel_value = sel_value | cell_sel[k];
        end
    end

    assign n_read_value = (op == OP_READ && n_status == ST_DONE) ? sel_value : NOT_FOUND;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on each accepted beat, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_read_value  <= n_read_value;
            r_status      <= n_status;
            r_entry_count <= n_cnt_ext[CNT_OUT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_read_value;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;

    // Count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CAP_CMP)
        else $error("entry count above capacity");

    // Count moves only on an accepted beat
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_count))
        else $error("entry count changed without a request");

    // Every accepted beat shows a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted request gave no result");

    // A refused insert reports a full list
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_entry_count == CNT_OUT_W'(CAPACITY)))
        else $error("full status without a full list");

endmodule

`default_nettype wire

FILE: test/tb_indexed_insert_delete_list_top.sv
// Testbench for indexed_insert_delete_list_top: directed and random request beats
// checked against an in-bench list predictor, with random idling on both channels.
// Depends on iidl_pkg and the RTL of the block.
module tb_indexed_insert_delete_list_top;
    timeunit 1ns;
    timeprecision 1ps;

    import iidl_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int QUIET_TAIL   = 120;
    localparam int SETTLE       = 8;
    localparam int OP_MAX       = {OPCODE_W{1'b1}};
    localparam int POS_MAX      = {POS_W{1'b1}};

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [POS_W-1:0]    pos;
        logic [DATA_W-1:0]   val;
    } t_list_req;

    typedef struct packed {
        logic [DATA_W-1:0]    rd;
        logic [STATUS_W-1:0]  st;
        logic [CNT_OUT_W-1:0] cnt;
    } t_list_result;

    typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} t_gen_mode;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [OPCODE_W-1:0]         i_opcode = '0;
    logic [POS_W-1:0]            i_position = '0;
    logic signed [DATA_W-1:0]    i_item_value = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic signed [DATA_W-1:0]    o_read_value;
    logic [STATUS_W-1:0]         o_status;
    logic [CNT_OUT_W-1:0]        o_entry_count;

    t_list_req                   request_q[$];
    t_list_result                predicted_results[$];
    logic [DATA_W-1:0]           list_q[$];
    t_list_result                got_want;
    t_list_req                   next_req;
    int                          gen_len = 0;
    int                          in_sent = 0;
    int                          in_accepts = 0;
    int                          in_gap = 0;
    int                          out_gap = 0;
    int                          idle_mode = 1;
    int                          cycle_cnt = 0;
    int                          fail_cnt = 0;

    indexed_insert_delete_list_top #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_entry_count(o_entry_count)
    );

    always #2 i_clk = ~i_clk;

    // Apply one request to the list copy and return the result it should give
    function automatic t_list_result list_apply(input t_list_req req);
        t_list_result r;
        int           p;
        bit           full;
        r.rd = NOT_FOUND;
        r.st = ST_DONE;
        p    = req.pos;
        full = list_q.size() >= CAPACITY;
        case (req.op)
            OP_READ: begin
                if (p < list_q.size()) r.rd = list_q[p];
                else r.st = ST_RANGE;
            end
            OP_HEAD: begin
                if (full) r.st = ST_FULL;
                else list_q.push_front(req.val);
            end
            OP_TAIL: begin
                if (full) r.st = ST_FULL;
                else list_q.push_back(req.val);
            end
            OP_AT: begin
                // range check wins over the full check
                if (p > list_q.size()) r.st = ST_RANGE;
                else if (full) r.st = ST_FULL;
                else list_q.insert(p, req.val);
            end
            OP_DELETE: begin
                if (p >= list_q.size()) r.st = ST_RANGE;
                else list_q.delete(p);
            end
            default: r.st = ST_RANGE;
        endcase
        r.cnt = CNT_OUT_W'(list_q.size());
        return r;
    endfunction

    // Queue one request beat and track the list length it leaves behind
    task automatic push_req(input logic [OPCODE_W-1:0] op, input int pos,
                            input logic [DATA_W-1:0] val);
        t_list_req r;
        r.op  = op;
        r.pos = pos[POS_W-1:0];
        r.val = val;
        request_q.push_back(r);
        case (op)
            OP_HEAD, OP_TAIL: if (gen_len < CAPACITY) gen_len++;
            OP_AT: if (pos <= gen_len && gen_len < CAPACITY) gen_len++;
            OP_DELETE: if (pos < gen_len) gen_len--;
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        fail_cnt++;
    endtask

    // Decide whether a side starts an idle burst this cycle
    function automatic bit idle_roll();
        if (request_q.size() < QUIET_TAIL) return 1'b0;
        case (idle_mode)
            1: return $urandom_range(0, 7) == 0;
            2: return $urandom_range(0, 2) == 0;
            default: return 1'b0;
        endcase
    endfunction

    // Count cycles, vary the idle density, stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 256 == 0) idle_mode <= $urandom_range(0, 2);
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Driver: present the next request beat, hold it while stalled
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_accepts == in_sent)) begin
            if (in_gap != 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (request_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (idle_roll()) begin
                in_gap     <= $urandom_range(0, 2);
                i_in_valid <= 1'b0;
            end else begin
                next_req     = request_q.pop_front();
                i_opcode     <= next_req.op;
                i_position   <= next_req.pos;
                i_item_value <= next_req.val;
                i_in_valid   <= 1'b1;
                in_sent      <= in_sent + 1;
            end
        end
    end

    // Result side: stall in short random bursts
    always @(negedge i_clk) begin
        if (out_gap != 0) begin
            out_gap     <= out_gap - 1;
            i_out_stall <= 1'b1;
        end else if (i_rst_n && idle_roll()) begin
            out_gap     <= $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predicted_results.push_back(list_apply({i_opcode, i_position, i_item_value}));
                in_accepts++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("result beat with nothing pending", o_read_value, '0);
                end else begin
                    got_want = predicted_results.pop_front();
                    if (o_read_value !== got_want.rd)
                        report_mismatch("read_value", o_read_value, got_want.rd);
                    if (o_status !== got_want.st)
                        report_mismatch("status", o_status, got_want.st);
                    if (o_entry_count !== got_want.cnt)
                        report_mismatch("entry_count", o_entry_count, got_want.cnt);
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        t_gen_mode         mode;
        int                n;
        int                roll;
        int                pick;
        int                total;
        logic [DATA_W-1:0] val;

        // empty list: every positional request is out of range
        push_req(OP_READ, 0, '0);
        push_req(OP_DELETE, 0, '0);
        push_req(OP_AT, 1, 32'h1234_5678);
        // insert at the count acts as a tail insert
        push_req(OP_AT, 0, 32'h7fff_ffff);
        push_req(OP_HEAD, 0, 32'h8000_0000);
        push_req(OP_TAIL, 0, 32'hffff_ffff);
        push_req(OP_TAIL, POS_MAX, 32'h0000_0000);
        push_req(OP_AT, 2, 32'h0000_0001);
        for (n = 0; n < 5; n++) push_req(OP_READ, n, 32'h5555_5555);
        // read past the end, near and far
        push_req(OP_READ, 5, '0);
        push_req(OP_READ, POS_MAX, '0);
        push_req(OP_AT, POS_MAX, 32'haaaa_aaaa);
        // unused opcodes change nothing
        for (n = OP_DELETE + 1; n <= OP_MAX; n++)
            push_req(OPCODE_W'(n), POS_MAX, 32'hffff_ffff);
        // delete the last, the first, then one in the middle, then one past the end
        push_req(OP_DELETE, 4, '0);
        push_req(OP_DELETE, 0, '0);
        push_req(OP_DELETE, 1, '0);
        push_req(OP_DELETE, 2, '0);
        push_req(OP_READ, 0, '0);
        push_req(OP_READ, 1, '0);

        // random part: mostly legal traffic that walks the list up to full and back
        mode = MODE_GROW;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: val = 32'h8000_0000;
                    1: val = 32'h7fff_ffff;
                    2: val = '1;
                    default: val = '0;
                endcase
            end else begin
                val = $urandom;
            end
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 99);
            if (roll < 8) begin
                push_req(OPCODE_W'($urandom_range(0, OP_MAX)), $urandom_range(0, POS_MAX), val);
            end else if ((mode == MODE_GROW && pick < 70) ||
                         (mode == MODE_SHRINK && pick < 10) ||
                         (mode == MODE_MIX && pick < 35)) begin
                case ($urandom_range(0, 2))
                    0: push_req(OP_HEAD, $urandom_range(0, POS_MAX), val);
                    1: push_req(OP_TAIL, $urandom_range(0, POS_MAX), val);
                    default: push_req(OP_AT, $urandom_range(0, gen_len), val);
                endcase
            end else if ((mode == MODE_GROW && pick < 90) ||
                         (mode == MODE_SHRINK && pick < 30) ||
                         (mode == MODE_MIX && pick < 65)) begin
                push_req(OP_READ, (gen_len == 0) ? 0 : $urandom_range(0, gen_len - 1), val);
            end else begin
                push_req(OP_DELETE, (gen_len == 0) ? 0 : $urandom_range(0, gen_len - 1), val);
            end
            // linger at full for a few refused inserts, turn around when empty
            if (mode == MODE_GROW && gen_len == CAPACITY && $urandom_range(0, 3) == 0)
                mode = MODE_SHRINK;
            else if (mode == MODE_SHRINK && gen_len == 0)
                mode = MODE_GROW;
            else if ($urandom_range(0, 79) == 0)
                mode = t_gen_mode'($urandom_range(0, 2));
        end
        total = request_q.size();

        // hold reset, then release it on a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (in_accepts != total) @(posedge i_clk);
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
